// ===== src/cvsm_pkg.sv =====
// Package for the chunk vertex seam mapper: payload types, configuration codes and constants.
`default_nettype none

package cvsm_pkg;

  // Limits of the map and of the chunk grid.
  localparam int MAX_MAP_CHUNKS = 256;
  localparam int MAX_CHUNK_DIMS = 255;

  // Field widths fixed by the interface.
  localparam int WORLD_W  = 32;
  localparam int DIMS_W   = 8;
  localparam int TRI_W    = 16;
  localparam int MAP_W    = 9;
  localparam int INDEX_W  = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Divider cell geometry: every cell brings in one numerator bit.
  localparam int REM_W       = 32;
  localparam int NUM_W       = 24;
  localparam int DIV1_STAGES = 24;
  localparam int DIV2_STAGES = 8;

  // Signed chunk coordinate, wide enough for the quotient plus one either way.
  localparam int COORD_W = 26;

  // Candidate slots per input: the chunk itself, two seam neighbours and the diagonal.
  localparam int SLOTS  = 4;
  localparam int SLOT_W = 2;

  // Reset values of the configuration registers.
  localparam logic [DIMS_W-1:0]  CHUNK_DIMS_RESET = 8'd16;
  localparam logic [TRI_W-1:0]   TRI_SIZE_RESET   = 16'd100;
  localparam logic [MAP_W-1:0]   MAP_CHUNKS_RESET = 9'd4;
  localparam logic [REM_W-1:0]   SIDE_RESET       = 32'(16 * 100 * 256);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHUNK_DIMS = 2'd0,
    CFG_TRI_SIZE   = 2'd1,
    CFG_MAP_CHUNKS = 2'd2
  } cfg_reg_t;

  // Input request payload.
  typedef struct packed {
    logic signed [WORLD_W-1:0] world_x;
    logic signed [WORLD_W-1:0] world_y;
    logic                      raise_flag;
  } in_t;

  // Result request payload.
  typedef struct packed {
    logic [INDEX_W-1:0] chunk_index;
    logic [DIMS_W-1:0]  vertex_x;
    logic [DIMS_W-1:0]  vertex_y;
    logic               raise_out;
    logic               last;
  } out_t;

  // State handed from one divider cell to the next.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quot;
  } cell_t;

  // One candidate chunk, already known to lie on the map when its mask bit is set.
  typedef struct packed {
    logic [DIMS_W-1:0] cx;
    logic [DIMS_W-1:0] cy;
    logic [DIMS_W-1:0] vx;
    logic [DIMS_W-1:0] vy;
  } cand_t;

  // All candidates of one input item.
  typedef struct packed {
    cand_t [SLOTS-1:0] slot;
    logic  [SLOTS-1:0] mask;
    logic              raise_flag;
  } cand_set_t;

  // Status of the result emitter towards the pipeline.
  typedef struct packed {
    logic can_load;
    logic pending;
  } emit_status_t;

endpackage

`default_nettype wire

// ===== src/cvsm_div_cell.sv =====
// One restoring-division cell: brings in a numerator bit, compares and subtracts.
`default_nettype none

module cvsm_div_cell
  import cvsm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [REM_W-1:0] divisor,
  input  wire cell_t            cell_in,
  output cell_t                 cell_out
);

  cell_t            cell_r;
  cell_t            cell_nxt;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             fits;

  // Shift the next numerator bit into the partial remainder and try the divisor.
  always_comb begin
    trial = {cell_in.rem, cell_in.num[NUM_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
    cell_nxt.rem  = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
    cell_nxt.num  = {cell_in.num[NUM_W-2:0], 1'b0};
    cell_nxt.quot = {cell_in.quot[NUM_W-2:0], fits};
  end

  // Payload register, moving with the rest of the chain.
  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

`default_nettype wire

// ===== src/cvsm_emitter.sv =====
// Candidate buffer and output register: sends one result request per cycle while out_ready is high.
`default_nettype none

module cvsm_emitter
  import cvsm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire cand_set_t        cand_in,
  input  wire logic [MAP_W-1:0] map_size,
  output emit_status_t          status,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_data
);

  logic [SLOTS-1:0]   mask_r;
  logic [SLOTS-1:0]   mask_nxt;
  logic [INDEX_W-1:0] idx_r [SLOTS];
  logic [DIMS_W-1:0]  vx_r  [SLOTS];
  logic [DIMS_W-1:0]  vy_r  [SLOTS];
  logic               raise_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_t               out_data_r;
  out_t               out_data_nxt;
  logic [SLOT_W-1:0]  sel;
  logic               found;
  logic [SLOTS-1:0]   remaining;
  logic               emit;
  logic [INDEX_W:0]   row_base [SLOTS];

  // Pick the earliest pending candidate and see what is left after it.
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int k = 0; k < SLOTS; k++) begin
      if (mask_r[k] && !found) begin
        sel   = SLOT_W'(k);
        found = 1'b1;
      end
    end
    remaining = mask_r & ~(SLOTS'(1) << sel);
  end

  assign emit            = (mask_r != '0) && (!out_valid_r || out_ready);
  assign status.pending  = mask_r != '0;
  assign status.can_load = (mask_r == '0) || (emit && (remaining == '0));

  // Row-major chunk index of every candidate, formed as the set is loaded.
  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      row_base[k] = (INDEX_W+1)'(cand_in.slot[k].cy) * (INDEX_W+1)'(map_size);
    end
  end

  // Pending mask: a new set replaces a finished one, otherwise slots retire one by one.
  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = cand_in.mask;
    end else if (emit) begin
      mask_nxt = remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  // Candidate payload storage.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < SLOTS; k++) begin
        idx_r[k] <= row_base[k][INDEX_W-1:0] + INDEX_W'(cand_in.slot[k].cx);
        vx_r[k]  <= cand_in.slot[k].vx;
        vy_r[k]  <= cand_in.slot[k].vy;
      end
      raise_r <= cand_in.raise_flag;
    end
  end

  // Output register: refilled whenever it is empty or being taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (!out_valid_r || out_ready) begin
      out_valid_nxt            = emit;
      out_data_nxt.chunk_index = idx_r[sel];
      out_data_nxt.vertex_x    = vx_r[sel];
      out_data_nxt.vertex_y    = vy_r[sel];
      out_data_nxt.raise_out   = raise_r;
      out_data_nxt.last        = remaining == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== src/chunk_vertex_seam_mapper.sv =====
// Top level of the chunk vertex seam mapper: configuration, divider cell chains and seam logic.
//
// Usage. A request on the in_ channel carries a world position in signed Q23.8 and a raise
// flag. The block finds the chunk by floor division by the chunk side, then the grid vertex
// inside it, and sends one result request on the out_ channel for every chunk on the map that
// shares that vertex, the final one marked last. A position whose chunks all lie off the map
// gives no result. The cfg_ port writes one of chunk_dims, tri_size and map_chunks per write.
//
// Pipeline. A request passes through a preparation stage, a chain of 24 division cells for
// the chunk, two fix-up stages, a chain of 8 division cells for the vertex, the seam stage,
// the candidate buffer and the output register.
//
// Throughput. The cell chains take a new request every cycle while the chain is not halted.
// The emitter sends one result per cycle from its buffer while out_ready is high; a request
// has up to four results, or none.
//
// Reset and stalls. rst_n clears every valid bit and restores the register defaults; nothing
// is in flight afterwards. When the receiver holds out_ready low the output register keeps its
// request, the buffer fills, and the whole chain halts with in_ready low until space returns.
`default_nettype none

module chunk_vertex_seam_mapper
  import cvsm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_t                      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  typedef struct packed {
    logic sign_x;
    logic sign_y;
    logic raise_flag;
  } side1_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic                      raise_flag;
  } side2_t;

  // Configuration, held in effective form.
  logic [DIMS_W-1:0] dims_r, dims_nxt;
  logic [TRI_W-1:0]  tri_r, tri_nxt;
  logic [MAP_W-1:0]  msize_r, msize_nxt;
  logic [REM_W-1:0]  side_r, side_nxt;
  logic [REM_W-1:0]  cell_div;
  logic [23:0]       side_prod;

  // Pipeline control.
  logic adv;
  emit_status_t emit_st;

  // Preparation stage.
  logic             p_valid_r;
  cell_t            p_x_r, p_y_r;
  side1_t           p_side_r;
  logic [REM_W-1:0] abs_x, abs_y;

  // First division chain.
  cell_t  c1x [DIV1_STAGES+1];
  cell_t  c1y [DIV1_STAGES+1];
  logic   v1_r [DIV1_STAGES];
  side1_t s1_r [DIV1_STAGES];

  // Fix-up stages.
  logic                      f1_valid_r;
  logic signed [COORD_W-1:0] f1_cx_r, f1_cy_r;
  logic [REM_W-1:0]          f1_rx_r, f1_ry_r;
  logic                      f1_raise_r;
  logic [REM_W-1:0]          n2x, n2y;
  logic                      f2_valid_r;
  cell_t                     f2_x_r, f2_y_r;
  side2_t                    f2_side_r;

  // Second division chain.
  cell_t  c2x [DIV2_STAGES+1];
  cell_t  c2y [DIV2_STAGES+1];
  logic   v2_r [DIV2_STAGES];
  side2_t s2_r [DIV2_STAGES];

  // Seam stage.
  logic                      a_valid_r;
  cand_set_t                 a_set_r;
  cand_set_t                 a_set_nxt;
  logic [DIMS_W-1:0]         vx, vy;
  logic signed [COORD_W-1:0] cx, cy;
  logic                      lx, hx, ly, hy, any_x, any_y, x_first;
  logic signed [COORD_W-1:0] xn_cx, yn_cy;
  logic [DIMS_W-1:0]         xn_vx, yn_vy;
  logic signed [COORD_W-1:0] ccx [SLOTS];
  logic signed [COORD_W-1:0] ccy [SLOTS];
  logic [DIMS_W-1:0]         cvx [SLOTS];
  logic [DIMS_W-1:0]         cvy [SLOTS];
  logic [SLOTS-1:0]          present;
  logic signed [COORD_W-1:0] msize_s;

  // Turns an unsigned quotient and remainder into a floor quotient for a signed numerator.
  function automatic logic signed [COORD_W-1:0] floor_quot(input logic neg,
                                                           input logic [NUM_W-1:0] qa,
                                                           input logic rnz);
    logic [COORD_W-1:0] qe;
    qe = COORD_W'(qa);
    if (neg) begin
      floor_quot = $signed(COORD_W'(0) - qe - COORD_W'(rnz));
    end else begin
      floor_quot = $signed(qe);
    end
  endfunction

  // The matching remainder, always in the range up to the chunk side.
  function automatic logic [REM_W-1:0] floor_rem(input logic neg,
                                                 input logic [REM_W-1:0] ra,
                                                 input logic [REM_W-1:0] side);
    floor_rem = (neg && (ra != '0)) ? (side - ra) : ra;
  endfunction

  // Configuration write decode; zero sizes count as one and the map is clamped.
  always_comb begin
    dims_nxt  = dims_r;
    tri_nxt   = tri_r;
    msize_nxt = msize_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_CHUNK_DIMS: begin
          dims_nxt = (cfg_data[DIMS_W-1:0] == '0) ? DIMS_W'(1) : cfg_data[DIMS_W-1:0];
        end
        CFG_TRI_SIZE: begin
          tri_nxt = (cfg_data[TRI_W-1:0] == '0) ? TRI_W'(1) : cfg_data[TRI_W-1:0];
        end
        CFG_MAP_CHUNKS: begin
          msize_nxt = (cfg_data[MAP_W-1:0] > MAP_W'(MAX_MAP_CHUNKS)) ?
                      MAP_W'(MAX_MAP_CHUNKS) : cfg_data[MAP_W-1:0];
        end
        default: begin
          dims_nxt = dims_r;
        end
      endcase
    end
    side_prod = 24'(dims_nxt) * 24'(tri_nxt);
    side_nxt  = {side_prod, 8'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r  <= CHUNK_DIMS_RESET;
      tri_r   <= TRI_SIZE_RESET;
      msize_r <= MAP_CHUNKS_RESET;
      side_r  <= SIDE_RESET;
    end else begin
      dims_r  <= dims_nxt;
      tri_r   <= tri_nxt;
      msize_r <= msize_nxt;
      side_r  <= side_nxt;
    end
  end

  // Grid cell width in Q23.8.
  assign cell_div = {8'b0, tri_r, 8'b0};

  // The chain moves as one whenever the seam stage can hand over its set.
  assign adv      = !a_valid_r || emit_st.can_load;
  assign in_ready = adv;

  // Preparation: magnitudes of the positions; the top byte is below any chunk side.
  assign abs_x = in_data.world_x[WORLD_W-1] ? (REM_W'(0) - REM_W'(in_data.world_x)) :
                                              REM_W'(in_data.world_x);
  assign abs_y = in_data.world_y[WORLD_W-1] ? (REM_W'(0) - REM_W'(in_data.world_y)) :
                                              REM_W'(in_data.world_y);

  always_ff @(posedge clk) begin
    if (adv) begin
      p_x_r.rem  <= REM_W'(abs_x[REM_W-1:NUM_W]);
      p_x_r.num  <= abs_x[NUM_W-1:0];
      p_x_r.quot <= '0;
      p_y_r.rem  <= REM_W'(abs_y[REM_W-1:NUM_W]);
      p_y_r.num  <= abs_y[NUM_W-1:0];
      p_y_r.quot <= '0;
      p_side_r.sign_x     <= in_data.world_x[WORLD_W-1];
      p_side_r.sign_y     <= in_data.world_y[WORLD_W-1];
      p_side_r.raise_flag <= in_data.raise_flag;
    end
  end

  // First chain: one quotient bit of the chunk coordinate per cell.
  assign c1x[0] = p_x_r;
  assign c1y[0] = p_y_r;

  for (genvar k = 0; k < DIV1_STAGES; k++) begin : g_div1
    cvsm_div_cell u_cell_x (
      .clk      (clk),
      .en       (adv),
      .divisor  (side_r),
      .cell_in  (c1x[k]),
      .cell_out (c1x[k+1])
    );
    cvsm_div_cell u_cell_y (
      .clk      (clk),
      .en       (adv),
      .divisor  (side_r),
      .cell_in  (c1y[k]),
      .cell_out (c1y[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r[0] <= p_side_r;
      for (int k = 1; k < DIV1_STAGES; k++) begin
        s1_r[k] <= s1_r[k-1];
      end
    end
  end

  // First fix-up: floor quotient and non-negative remainder.
  always_ff @(posedge clk) begin
    if (adv) begin
      f1_cx_r    <= floor_quot(s1_r[DIV1_STAGES-1].sign_x, c1x[DIV1_STAGES].quot,
                               c1x[DIV1_STAGES].rem != '0);
      f1_cy_r    <= floor_quot(s1_r[DIV1_STAGES-1].sign_y, c1y[DIV1_STAGES].quot,
                               c1y[DIV1_STAGES].rem != '0);
      f1_rx_r    <= floor_rem(s1_r[DIV1_STAGES-1].sign_x, c1x[DIV1_STAGES].rem, side_r);
      f1_ry_r    <= floor_rem(s1_r[DIV1_STAGES-1].sign_y, c1y[DIV1_STAGES].rem, side_r);
      f1_raise_r <= s1_r[DIV1_STAGES-1].raise_flag;
    end
  end

  // Second fix-up: add half a cell so that the vertex rounds half up.
  assign n2x = f1_rx_r + REM_W'({tri_r, 7'b0});
  assign n2y = f1_ry_r + REM_W'({tri_r, 7'b0});

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_x_r.rem  <= REM_W'(n2x[REM_W-1:8]);
      f2_x_r.num  <= {n2x[7:0], 16'b0};
      f2_x_r.quot <= '0;
      f2_y_r.rem  <= REM_W'(n2y[REM_W-1:8]);
      f2_y_r.num  <= {n2y[7:0], 16'b0};
      f2_y_r.quot <= '0;
      f2_side_r.cx         <= f1_cx_r;
      f2_side_r.cy         <= f1_cy_r;
      f2_side_r.raise_flag <= f1_raise_r;
    end
  end

  // Second chain: one vertex bit per cell.
  assign c2x[0] = f2_x_r;
  assign c2y[0] = f2_y_r;

  for (genvar k = 0; k < DIV2_STAGES; k++) begin : g_div2
    cvsm_div_cell u_cell_x (
      .clk      (clk),
      .en       (adv),
      .divisor  (cell_div),
      .cell_in  (c2x[k]),
      .cell_out (c2x[k+1])
    );
    cvsm_div_cell u_cell_y (
      .clk      (clk),
      .en       (adv),
      .divisor  (cell_div),
      .cell_in  (c2y[k]),
      .cell_out (c2y[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r[0] <= f2_side_r;
      for (int k = 1; k < DIV2_STAGES; k++) begin
        s2_r[k] <= s2_r[k-1];
      end
    end
  end

  // Valid bits of every stage up to the seam stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r  <= 1'b0;
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
      a_valid_r  <= 1'b0;
      for (int k = 0; k < DIV1_STAGES; k++) begin
        v1_r[k] <= 1'b0;
      end
      for (int k = 0; k < DIV2_STAGES; k++) begin
        v2_r[k] <= 1'b0;
      end
    end else if (adv) begin
      p_valid_r <= in_valid;
      v1_r[0]   <= p_valid_r;
      for (int k = 1; k < DIV1_STAGES; k++) begin
        v1_r[k] <= v1_r[k-1];
      end
      f1_valid_r <= v1_r[DIV1_STAGES-1];
      f2_valid_r <= f1_valid_r;
      v2_r[0]    <= f2_valid_r;
      for (int k = 1; k < DIV2_STAGES; k++) begin
        v2_r[k] <= v2_r[k-1];
      end
      a_valid_r <= v2_r[DIV2_STAGES-1];
    end
  end

  // Seam stage: list the chunks sharing the vertex, in order, and keep those on the map.
  always_comb begin
    vx      = c2x[DIV2_STAGES].quot[DIMS_W-1:0];
    vy      = c2y[DIV2_STAGES].quot[DIMS_W-1:0];
    cx      = s2_r[DIV2_STAGES-1].cx;
    cy      = s2_r[DIV2_STAGES-1].cy;
    lx      = vx == '0;
    hx      = vx == dims_r;
    ly      = vy == '0;
    hy      = vy == dims_r;
    any_x   = lx || hx;
    any_y   = ly || hy;
    x_first = !(hx && ly);
    xn_cx   = lx ? (cx - COORD_W'(1)) : (cx + COORD_W'(1));
    yn_cy   = ly ? (cy - COORD_W'(1)) : (cy + COORD_W'(1));
    xn_vx   = lx ? dims_r : '0;
    yn_vy   = ly ? dims_r : '0;

    // The chunk itself.
    ccx[0] = cx;
    ccy[0] = cy;
    cvx[0] = vx;
    cvy[0] = vy;

    // First and second seam neighbour; on a corner low Y comes ahead of high X.
    if (any_x && (!any_y || x_first)) begin
      ccx[1] = xn_cx;
      ccy[1] = cy;
      cvx[1] = xn_vx;
      cvy[1] = vy;
      ccx[2] = cx;
      ccy[2] = yn_cy;
      cvx[2] = vx;
      cvy[2] = yn_vy;
    end else begin
      ccx[1] = cx;
      ccy[1] = yn_cy;
      cvx[1] = vx;
      cvy[1] = yn_vy;
      ccx[2] = xn_cx;
      ccy[2] = cy;
      cvx[2] = xn_vx;
      cvy[2] = vy;
    end

    // Diagonal chunk at a corner.
    ccx[3] = xn_cx;
    ccy[3] = yn_cy;
    cvx[3] = xn_vx;
    cvy[3] = yn_vy;

    present = {any_x && any_y, any_x && any_y, any_x || any_y, 1'b1};
    msize_s = $signed(COORD_W'(msize_r));

    for (int k = 0; k < SLOTS; k++) begin
      a_set_nxt.mask[k] = present[k] && (ccx[k] >= 0) && (ccx[k] < msize_s) &&
                          (ccy[k] >= 0) && (ccy[k] < msize_s);
      a_set_nxt.slot[k].cx = ccx[k][DIMS_W-1:0];
      a_set_nxt.slot[k].cy = ccy[k][DIMS_W-1:0];
      a_set_nxt.slot[k].vx = cvx[k];
      a_set_nxt.slot[k].vy = cvy[k];
    end
    a_set_nxt.raise_flag = s2_r[DIV2_STAGES-1].raise_flag;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_set_r <= a_set_nxt;
    end
  end

  // Candidate buffer and result register.
  cvsm_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (a_valid_r && emit_st.can_load),
    .cand_in   (a_set_r),
    .map_size  (msize_r),
    .status    (emit_st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A new result request only appears when the buffer held a pending candidate.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(emit_st.pending))
    else $error("result request raised with an empty candidate buffer");

  // Reset leaves no result request behind.
  assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result request present just after reset");

  // The seam stage keeps its set unchanged while the buffer cannot take it.
  assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !emit_st.can_load) |=> (a_valid_r && $stable(a_set_r)))
    else $error("seam stage set lost while the buffer was busy");

endmodule

`default_nettype wire
